### sv/rgba_filter_with_gaussian_blur_macros.svh
// Assertion macros for the RGBA filter block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef RGBA_FILTER_WITH_GAUSSIAN_BLUR_MACROS_SVH
`define RGBA_FILTER_WITH_GAUSSIAN_BLUR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGBF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RGBF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbf: next-cycle check failed");

`endif

### sv/rgbf_pkg.sv
// Shared types, constants and arithmetic helpers of the RGBA filter block.
// No dependencies; imported by the top level.
package rgbf_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int WidthW    = ColW + 1;
  localparam int HeightW   = RowW + 1;

  // Filter mode codes.
  localparam logic [2:0] MODE_COPY   = 3'd0;
  localparam logic [2:0] MODE_INVERT = 3'd1;
  localparam logic [2:0] MODE_GRAY   = 3'd2;
  localparam logic [2:0] MODE_SEPIA  = 3'd3;
  localparam logic [2:0] MODE_BRIGHT = 3'd4;
  localparam logic [2:0] MODE_BLUR   = 3'd5;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_GAIN   = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_index_t;

  localparam logic [15:0] GainReset = 16'd307;

  // Blur taps over 256.
  localparam logic [16:0] TapSide = 17'd70;
  localparam logic [16:0] TapMid  = 17'd116;

  typedef struct packed {
    logic       action;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_last;
  } out_item_t;

  // Clamp to 0..255.
  function automatic logic [7:0] sat8(input logic [16:0] v);
    return (v > 17'd255) ? 8'hFF : v[7:0];
  endfunction

  // Three-tap blur of RGB on packed pixels (red in the low byte); alpha from the centre.
  function automatic logic [31:0] tap3(input logic [31:0] l, input logic [31:0] c,
                                       input logic [31:0] r);
    logic [16:0] s;
    logic [31:0] o;
    o = '0;
    o[31:24] = c[31:24];
    for (int k = 0; k < 3; k++) begin
      s = TapSide * 17'(l[8*k +: 8]) + TapMid * 17'(c[8*k +: 8]) + TapSide * 17'(r[8*k +: 8]);
      o[8*k +: 8] = sat8(17'(s[16:8]));
    end
    return o;
  endfunction

endpackage

### sv/rgbf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; written as read-before-write on a shared address.
module rgbf_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
  input  logic [Width-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
  output logic [Width-1:0]                        rd_data_r
);

  logic [Width-1:0] mem_r [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

### sv/rgba_filter_with_gaussian_blur.sv
// RGBA colour filters and streaming separable 3x3 Gaussian blur, top level.
// A result is registered in the read stage (row-store read and stage-1 registers), then
// in the output register; both hold while the output is stalled. Throughput: one item
// per cycle in every mode while the output is not stalled; blur output trails input by
// about one row. Reset sets mode, gain and geometry defaults and clears counters and
// tap window; row-store contents stay undefined until written (no clearing pass).
`include "rgba_filter_with_gaussian_blur_macros.svh"

module rgba_filter_with_gaussian_blur import rgbf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    OP_COPY, OP_INVERT, OP_GRAY, OP_SEPIA, OP_BRIGHT, OP_BLUR
  } op_t;

  // Source of one vertical tap: row bank 0, row bank 1 or the fresh horizontal result.
  typedef enum logic [1:0] { SEL_B0, SEL_B1, SEL_HV } src_t;

  // Configuration registers.
  logic [2:0]         mode_r;
  logic [15:0]        gain_r;
  logic [WidthW-1:0]  fw_r;
  logic [HeightW-1:0] fh_r;

  // Stream state.
  logic [ColW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RowW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic            flush_r, flush_nxt;
  logic [31:0]     t0_r, t0_nxt, t1_r, t1_nxt;

  // Read stage registers.
  logic            s1_valid_r, s1_valid_nxt;
  logic            s1_emit_r, s1_emit_nxt;
  logic            s1_we_r, s1_we_nxt;
  logic            s1_wbank_r, s1_wbank_nxt;
  logic [ColW-1:0] s1_wcol_r, s1_wcol_nxt;
  logic [31:0]     s1_hv_r, s1_hv_nxt;
  logic [31:0]     s1_pix_r, s1_pix_nxt;
  logic            s1_last_r, s1_last_nxt;
  op_t             s1_op_r, s1_op_nxt;
  src_t            s1_up_r, s1_up_nxt, s1_mid_r, s1_mid_nxt, s1_dn_r, s1_dn_nxt;
  logic [1:0]      fwd_r, fwd_nxt;
  logic [31:0]     fwd_data_r;

  // Output register.
  logic            out_valid_r;
  out_item_t       out_data_r, out_data_nxt;

  // Stage 0 combinational terms.
  logic               advance, accept, blur;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic               end_row, end_frame, first_pos;
  logic [RowW-1:0]    py, ly;
  logic [ColW-1:0]    px, rd_col;
  logic [31:0]        pix, right_tap, hv, dn_drain;
  logic               ox_end, dn_special, drain_last;
  src_t               c_sel;
  op_t                colour_op;

  // Stage 1 combinational terms.
  logic [31:0] rd0, rd1, b0, b1, up_v, mid_v, dn_v, vres, cres;
  logic [24:0] sum_a, sum_b, sum_c;
  logic [23:0] pr_r, pr_g, pr_b;

  assign advance   = !(out_valid_r && out_stall);
  assign in_stall  = !advance;
  assign accept    = in_valid && advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign blur      = (mode_r == MODE_BLUR);

  // Geometry saturated to the supported frame size; zero acts as one.
  always_comb begin
    if (fw_r == '0) begin
      w_eff = WidthW'(1);
    end else if (fw_r > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = fw_r;
    end
    if (fh_r == '0) begin
      h_eff = HeightW'(1);
    end else if (fh_r > HeightW'(MaxHeight)) begin
      h_eff = HeightW'(MaxHeight);
    end else begin
      h_eff = fh_r;
    end
  end

  // Position and tap terms of the arriving item.
  assign pix        = {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};
  assign end_row    = ({1'b0, in_col_r} + WidthW'(1)) >= w_eff;
  assign end_frame  = end_row && (({1'b0, in_row_r} + HeightW'(1)) >= h_eff);
  assign first_pos  = (in_col_r == '0) && (in_row_r == '0);
  assign py         = (in_col_r != '0) ? in_row_r : in_row_r - RowW'(1);
  assign px         = (in_col_r != '0) ? in_col_r - ColW'(1) : ColW'(w_eff - WidthW'(1));
  assign right_tap  = (in_col_r != '0) ? pix : t1_r;
  assign hv         = tap3(t0_r, t1_r, right_tap);
  assign dn_drain   = tap3(t0_r, t1_r, t1_r);
  assign ly         = (({1'b0, out_row_r} + HeightW'(1)) < h_eff) ? out_row_r + RowW'(1)
                                                                   : RowW'(h_eff - HeightW'(1));
  assign ox_end     = ({1'b0, out_col_r} + WidthW'(1)) >= w_eff;
  assign dn_special = ({1'b0, ly} == h_eff - HeightW'(1)) && ox_end;
  assign drain_last = (({1'b0, out_row_r} + HeightW'(1)) >= h_eff) && ox_end;
  assign rd_col     = in_data.action ? out_col_r : px;

  // Colour operation of the current mode; undefined codes copy.
  always_comb begin
    unique case (mode_r)
      MODE_INVERT: colour_op = OP_INVERT;
      MODE_GRAY:   colour_op = OP_GRAY;
      MODE_SEPIA:  colour_op = OP_SEPIA;
      MODE_BRIGHT: colour_op = OP_BRIGHT;
      default:     colour_op = OP_COPY;
    endcase
  end

  // Stage 0: state update and issue of the row-store read.
  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    flush_nxt    = flush_r;
    t0_nxt       = t0_r;
    t1_nxt       = t1_r;
    s1_valid_nxt = accept;
    s1_emit_nxt  = 1'b0;
    s1_we_nxt    = 1'b0;
    s1_wbank_nxt = py[0];
    s1_wcol_nxt  = px;
    s1_hv_nxt    = hv;
    s1_pix_nxt   = pix;
    s1_last_nxt  = end_frame;
    s1_op_nxt    = OP_BLUR;
    s1_up_nxt    = py[0] ? SEL_B1 : SEL_B0;
    s1_mid_nxt   = py[0] ? SEL_B0 : SEL_B1;
    s1_dn_nxt    = SEL_HV;
    c_sel        = SEL_HV;
    if (accept && in_data.action) begin
      // Drain step: emit the next pending vertical result.
      if (blur && flush_r) begin
        s1_emit_nxt  = 1'b1;
        s1_last_nxt  = drain_last;
        s1_we_nxt    = dn_special;
        s1_wbank_nxt = ly[0];
        s1_wcol_nxt  = out_col_r;
        s1_hv_nxt    = dn_drain;
        s1_dn_nxt    = dn_special ? SEL_HV : (ly[0] ? SEL_B1 : SEL_B0);
        c_sel        = (ly == out_row_r) ? s1_dn_nxt : (out_row_r[0] ? SEL_B1 : SEL_B0);
        s1_mid_nxt   = c_sel;
        s1_up_nxt    = (out_row_r == '0) ? c_sel : (out_row_r[0] ? SEL_B0 : SEL_B1);
        if (drain_last) begin
          flush_nxt   = 1'b0;
          out_row_nxt = '0;
          out_col_nxt = '0;
        end else if (ox_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RowW'(1);
        end else begin
          out_col_nxt = out_col_r + ColW'(1);
        end
      end
    end else if (accept) begin
      if (!blur) begin
        s1_emit_nxt = 1'b1;
        s1_op_nxt   = colour_op;
      end else if (first_pos) begin
        flush_nxt   = 1'b0;
        out_row_nxt = '0;
        out_col_nxt = '0;
        t0_nxt      = pix;
        t1_nxt      = pix;
      end else begin
        // Horizontal result of the previous pixel; vertical result of the one above it.
        s1_we_nxt   = 1'b1;
        s1_emit_nxt = (py != '0);
        s1_last_nxt = ({1'b0, py} >= h_eff) && (({1'b0, px} + WidthW'(1)) >= w_eff);
        if (py == RowW'(1)) begin
          s1_up_nxt = s1_mid_nxt;
        end
        if (py != '0) begin
          if (({1'b0, px} + WidthW'(1)) >= w_eff) begin
            out_row_nxt = py;
            out_col_nxt = '0;
          end else begin
            out_row_nxt = py - RowW'(1);
            out_col_nxt = px + ColW'(1);
          end
        end
        if (in_col_r != '0) begin
          t0_nxt = t1_r;
          t1_nxt = pix;
        end else begin
          t0_nxt = pix;
          t1_nxt = pix;
        end
      end
      if (blur && end_frame) begin
        flush_nxt = 1'b1;
      end
      if (end_row) begin
        in_col_nxt = '0;
        in_row_nxt = end_frame ? '0 : in_row_r + RowW'(1);
      end else begin
        in_col_nxt = in_col_r + ColW'(1);
      end
    end
  end

  // Forwarding of a write that lands in the same cycle as this read.
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      fwd_nxt[b] = s1_valid_r && s1_we_r && (s1_wbank_r == 1'(b)) && (s1_wcol_r == rd_col);
    end
  end

  // Row store: one bank per row parity, read at the same column.
  rgbf_ram #(.Width(32), .Depth(MaxWidth)) u_bank0 (
    .clk       (clk),
    .wr_en     (advance && s1_valid_r && s1_we_r && !s1_wbank_r),
    .wr_addr   (s1_wcol_r),
    .wr_data   (s1_hv_r),
    .rd_en     (advance),
    .rd_addr   (rd_col),
    .rd_data_r (rd0)
  );

  rgbf_ram #(.Width(32), .Depth(MaxWidth)) u_bank1 (
    .clk       (clk),
    .wr_en     (advance && s1_valid_r && s1_we_r && s1_wbank_r),
    .wr_addr   (s1_wcol_r),
    .wr_data   (s1_hv_r),
    .rd_en     (advance),
    .rd_addr   (rd_col),
    .rd_data_r (rd1)
  );

  // Stage 1: vertical taps from the store, with forwarding.
  assign b0 = fwd_r[0] ? fwd_data_r : rd0;
  assign b1 = fwd_r[1] ? fwd_data_r : rd1;

  always_comb begin
    case (s1_up_r)
      SEL_B0:  up_v = b0;
      SEL_B1:  up_v = b1;
      default: up_v = s1_hv_r;
    endcase
    case (s1_mid_r)
      SEL_B0:  mid_v = b0;
      SEL_B1:  mid_v = b1;
      default: mid_v = s1_hv_r;
    endcase
    case (s1_dn_r)
      SEL_B0:  dn_v = b0;
      SEL_B1:  dn_v = b1;
      default: dn_v = s1_hv_r;
    endcase
  end

  assign vres = tap3(up_v, mid_v, dn_v);

  // Stage 1: colour modes on the registered pixel.
  always_comb begin
    sum_a = '0;
    sum_b = '0;
    sum_c = '0;
    pr_r  = 24'(s1_pix_r[7:0])   * 24'(gain_r);
    pr_g  = 24'(s1_pix_r[15:8])  * 24'(gain_r);
    pr_b  = 24'(s1_pix_r[23:16]) * 24'(gain_r);
    cres  = s1_pix_r;
    case (s1_op_r)
      OP_INVERT: begin
        cres = {s1_pix_r[31:24], ~s1_pix_r[23:0]};
      end
      OP_GRAY: begin
        sum_a = 25'(s1_pix_r[7:0]) * 25'd19595 + 25'(s1_pix_r[15:8]) * 25'd38470
              + 25'(s1_pix_r[23:16]) * 25'd7471;
        cres  = {s1_pix_r[31:24], {3{sat8(17'(sum_a[24:16]))}}};
      end
      OP_SEPIA: begin
        sum_a = 25'(s1_pix_r[7:0]) * 25'd25756 + 25'(s1_pix_r[15:8]) * 25'd50397
              + 25'(s1_pix_r[23:16]) * 25'd12386;
        sum_b = 25'(s1_pix_r[7:0]) * 25'd22872 + 25'(s1_pix_r[15:8]) * 25'd44958
              + 25'(s1_pix_r[23:16]) * 25'd11010;
        sum_c = 25'(s1_pix_r[7:0]) * 25'd17826 + 25'(s1_pix_r[15:8]) * 25'd34996
              + 25'(s1_pix_r[23:16]) * 25'd8585;
        cres  = {s1_pix_r[31:24], sat8(17'(sum_c[24:16])), sat8(17'(sum_b[24:16])),
                 sat8(17'(sum_a[24:16]))};
      end
      OP_BRIGHT: begin
        cres = {s1_pix_r[31:24], sat8({1'b0, pr_b[23:8]}), sat8({1'b0, pr_g[23:8]}),
                sat8({1'b0, pr_r[23:8]})};
      end
      default: begin
        cres = s1_pix_r;
      end
    endcase
  end

  // Result packing for the output register.
  always_comb begin
    logic [31:0] res;
    res = (s1_op_r == OP_BLUR) ? vres : cres;
    out_data_nxt.red_out    = res[7:0];
    out_data_nxt.green_out  = res[15:8];
    out_data_nxt.blue_out   = res[23:16];
    out_data_nxt.alpha_out  = res[31:24];
    out_data_nxt.frame_last = s1_last_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_COPY;
      gain_r      <= GainReset;
      fw_r        <= WidthW'(MaxWidth);
      fh_r        <= HeightW'(1024);
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      flush_r     <= 1'b0;
      t0_r        <= '0;
      t1_r        <= '0;
      s1_valid_r  <= 1'b0;
      s1_emit_r   <= 1'b0;
      s1_we_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_MODE:   mode_r <= cfg_data[2:0];
          CFG_GAIN:   gain_r <= cfg_data;
          CFG_WIDTH:  fw_r   <= cfg_data[WidthW-1:0];
          CFG_HEIGHT: fh_r   <= cfg_data[HeightW-1:0];
          default:    mode_r <= mode_r;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      flush_r   <= flush_nxt;
      t0_r      <= t0_nxt;
      t1_r      <= t1_nxt;
      if (advance) begin
        s1_valid_r  <= s1_valid_nxt;
        s1_emit_r   <= s1_emit_nxt;
        s1_we_r     <= s1_we_nxt;
        out_valid_r <= s1_valid_r && s1_emit_r;
      end
    end
  end

  // Payload registers of the pipeline.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_wbank_r <= s1_wbank_nxt;
      s1_wcol_r  <= s1_wcol_nxt;
      s1_hv_r    <= s1_hv_nxt;
      s1_pix_r   <= s1_pix_nxt;
      s1_last_r  <= s1_last_nxt;
      s1_op_r    <= s1_op_nxt;
      s1_up_r    <= s1_up_nxt;
      s1_mid_r   <= s1_mid_nxt;
      s1_dn_r    <= s1_dn_nxt;
      fwd_r      <= fwd_nxt;
      fwd_data_r <= s1_hv_r;
      out_data_r <= out_data_nxt;
    end
  end

  // Checks on pipeline control.
  `RGBF_ASSERT_IMP(a_reset_clean, $past(!rst_n), !out_valid && !s1_valid_r)
  `RGBF_ASSERT_IMP(a_stall_only_full, in_stall, out_valid)
  `RGBF_ASSERT_NXT(a_idle_drain_silent, in_valid && !in_stall && in_data.action && !flush_r, !s1_emit_r)

endmodule

### tb/sv/rgba_filter_with_gaussian_blur_tb.sv
// Testbench for the RGBA filter block with streaming 3x3 Gaussian blur.
// Depends on rgbf_pkg and the rgba_filter_with_gaussian_blur top level;
// a scoreboard class predicts every result from the accepted input transfers.
`timescale 1ns / 100ps

module rgba_filter_with_gaussian_blur_tb;
  import rgbf_pkg::*;

  // Scoreboard: keeps its own copy of registers, row store and counters.
  class pixel_scoreboard;
    logic [2:0]  mode;
    logic [15:0] gain;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [31:0] line_mem [2 * MaxWidth];
    logic [31:0] taps [3];
    int unsigned col_in, row_in, col_out, row_out;
    bit          drain_owed;
    out_item_t   pending_px [$];
    int          errors;

    function new();
      mode = MODE_COPY;
      gain = GainReset;
      width_reg = 11'd1024;
      height_reg = 13'd1024;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (taps[i]) taps[i] = '0;
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      drain_owed = 0;
      errors = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > MaxHeight) return MaxHeight;
      return height_reg;
    endfunction

    function bit at_frame_start();
      return col_in == 0 && row_in == 0;
    endfunction

    // Register write as the block sees it; fields keep only their own width.
    function void write_reg(cfg_index_t idx, logic [15:0] val);
      case (idx)
        CFG_MODE: begin
          mode = val[2:0];
        end
        CFG_GAIN: begin
          gain = val;
        end
        CFG_WIDTH: begin
          width_reg = val[10:0];
        end
        default: begin
          height_reg = val[12:0];
        end
      endcase
    endfunction

    function int unsigned mem_addr(int unsigned row, int unsigned col);
      if (col >= MaxWidth) col = MaxWidth - 1;
      return (row & 1) * MaxWidth + col;
    endfunction

    function logic [7:0] clip(int unsigned v);
      return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    // Three-tap blur of RGB; alpha follows the centre pixel.
    function logic [31:0] blend3(logic [31:0] l, logic [31:0] c, logic [31:0] r);
      logic [31:0] o;
      o[31:24] = c[31:24];
      for (int k = 0; k < 3; k++)
        o[8*k +: 8] = clip((70 * l[8*k +: 8] + 116 * c[8*k +: 8] + 70 * r[8*k +: 8]) >> 8);
      return o;
    endfunction

    // Color modes; codes 6 and 7 fall through to copy.
    function logic [31:0] recolor(logic [31:0] p);
      int unsigned r, g, b;
      logic [7:0] y;
      r = p[7:0];
      g = p[15:8];
      b = p[23:16];
      case (mode)
        MODE_INVERT: return {p[31:24], ~p[23:16], ~p[15:8], ~p[7:0]};
        MODE_GRAY: begin
          y = clip((19595 * r + 38470 * g + 7471 * b) >> 16);
          return {p[31:24], y, y, y};
        end
        MODE_SEPIA: return {p[31:24], clip((17826 * r + 34996 * g + 8585 * b) >> 16),
                            clip((22872 * r + 44958 * g + 11010 * b) >> 16),
                            clip((25756 * r + 50397 * g + 12386 * b) >> 16)};
        MODE_BRIGHT: return {p[31:24], clip((b * gain) >> 8), clip((g * gain) >> 8),
                             clip((r * gain) >> 8)};
        default: return p;
      endcase
    endfunction

    function void push_px(logic [31:0] p, bit last);
      out_item_t o;
      o.red_out = p[7:0];
      o.green_out = p[15:8];
      o.blue_out = p[23:16];
      o.alpha_out = p[31:24];
      o.frame_last = last;
      pending_px.push_back(o);
    endfunction

    // Accepted input transfer: update the state and queue any result it causes.
    function void note_input(in_item_t it);
      int unsigned w, h, x, y, oy, ox, ly, py, px, slot;
      logic [31:0] p, centre, up, down, hv, mid;
      bit blur, last, end_row, end_frame;
      w = eff_w();
      h = eff_h();
      blur = (mode == MODE_BLUR);
      if (it.action) begin
        if (!blur || !drain_owed) return;
        oy = row_out;
        ox = col_out;
        ly = (oy + 1 < h) ? oy + 1 : h - 1;
        centre = line_mem[mem_addr(oy, ox)];
        up = (oy >= 1) ? line_mem[mem_addr(oy - 1, ox)] : centre;
        if (ly == h - 1 && ox + 1 >= w) begin
          down = blend3(taps[0], taps[1], taps[1]);
          line_mem[mem_addr(ly, ox)] = down;
        end else begin
          down = line_mem[mem_addr(ly, ox)];
        end
        if (ly == oy) centre = down;
        if (oy == 0) up = centre;
        last = (oy + 1 >= h) && (ox + 1 >= w);
        push_px(blend3(up, centre, down), last);
        if (last) begin
          drain_owed = 0;
          row_out = 0;
          col_out = 0;
        end else if (col_out + 1 >= w) begin
          col_out = 0;
          row_out++;
        end else begin
          col_out++;
        end
        return;
      end
      p = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
      x = col_in;
      y = row_in;
      end_row = (x + 1 >= w);
      end_frame = end_row && (y + 1 >= h);
      if (!blur) begin
        push_px(recolor(p), end_frame);
      end else if (x == 0 && y == 0) begin
        // First pixel of a frame drops whatever was left undrained.
        drain_owed = 0;
        row_out = 0;
        col_out = 0;
        taps[0] = p;
        taps[1] = p;
        taps[2] = p;
      end else begin
        py = (x > 0) ? y : y - 1;
        px = (x > 0) ? x - 1 : w - 1;
        slot = mem_addr(py, px);
        taps[2] = (x > 0) ? p : taps[1];
        hv = blend3(taps[0], taps[1], taps[2]);
        if (py >= 1) begin
          mid = line_mem[mem_addr(py - 1, px)];
          up = (py >= 2) ? line_mem[slot] : mid;
          push_px(blend3(up, mid, hv), (py >= h) && (px + 1 >= w));
          if (px + 1 >= w) begin
            row_out = py;
            col_out = 0;
          end else begin
            row_out = py - 1;
            col_out = px + 1;
          end
        end
        line_mem[slot] = hv;
        if (x > 0) begin
          taps[0] = taps[1];
          taps[1] = p;
        end else begin
          taps[0] = p;
          taps[1] = p;
          taps[2] = p;
        end
      end
      if (blur && end_frame) drain_owed = 1;
      if (end_row) begin
        col_in = 0;
        row_in = end_frame ? 0 : y + 1;
      end else begin
        col_in = x + 1;
      end
    endfunction

    // Accepted result transfer: compare with the oldest expected pixel.
    function void check_result(out_item_t got);
      out_item_t exp_px;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_px = pending_px.pop_front();
      if (got.red_out !== exp_px.red_out)
        $display("%0t: red expected %h got %h", $time, exp_px.red_out, got.red_out);
      if (got.green_out !== exp_px.green_out)
        $display("%0t: green expected %h got %h", $time, exp_px.green_out, got.green_out);
      if (got.blue_out !== exp_px.blue_out)
        $display("%0t: blue expected %h got %h", $time, exp_px.blue_out, got.blue_out);
      if (got.alpha_out !== exp_px.alpha_out)
        $display("%0t: alpha expected %h got %h", $time, exp_px.alpha_out, got.alpha_out);
      if (got.frame_last !== exp_px.frame_last)
        $display("%0t: frame_last expected %b got %b", $time, exp_px.frame_last,
                 got.frame_last);
      if (got !== exp_px) errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  pixel_scoreboard sb;
  int  pixels_sent;
  bit  quiet;     // no idling on either side during this phase
  bit  hold_req;  // ask the receiver for one long hold-off

  rgba_filter_with_gaussian_blur u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Run limit.
  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stall, plus one long hold-off on request.
  initial begin
    int unsigned n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else begin
        n = gap_len();
        out_stall <= (n != 0);
        repeat ((n != 0) ? n : $urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Result transfers go to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic send_item(in_item_t it);
    int unsigned n;
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic send_drain();
    in_item_t it;
    it = {1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    send_item(it);
  endtask

  function automatic logic [7:0] chan_val(bit extreme);
    logic [7:0] tbl [4] = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    return extreme ? tbl[$urandom_range(0, 3)] : 8'($urandom);
  endfunction

  // Waits until every expected result has arrived and the pipeline is quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Holds the write until it is taken; the caller drops cfg_valid after the last one.
  task automatic write_reg(cfg_index_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // One whole frame; in blur mode the drain transfers follow, sometimes cut short.
  task automatic send_frame(bit extreme, bit full_drain);
    int unsigned total;
    in_item_t it;
    total = sb.eff_w() * sb.eff_h();
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(0, 19) == 0) send_drain();
      it.action = 1'b0;
      it.red_in = chan_val(extreme);
      it.green_in = chan_val(extreme);
      it.blue_in = chan_val(extreme);
      it.alpha_in = chan_val(extreme);
      send_item(it);
      pixels_sent++;
    end
    while (sb.drain_owed && (full_drain || $urandom_range(0, 9) != 0)) send_drain();
    if ($urandom_range(0, 3) == 0) send_drain();
  endtask

  // One phase: idle, program all registers, then send frames.
  task automatic run_phase(logic [15:0] mode_raw, logic [15:0] gain_raw,
                           logic [15:0] w_raw, logic [15:0] h_raw, int frames,
                           bit extreme);
    wait_idle();
    write_reg(CFG_MODE, mode_raw);
    write_reg(CFG_GAIN, gain_raw);
    write_reg(CFG_WIDTH, w_raw);
    write_reg(CFG_HEIGHT, h_raw);
    cfg_valid <= 1'b0;
    quiet = ($urandom_range(0, 4) == 0);
    for (int f = 0; f < frames; f++) send_frame(extreme, $urandom_range(0, 5) != 0);
  endtask

  function automatic logic [15:0] hi_noise(int unsigned v, int unsigned bits);
    return 16'(v) | (16'($urandom) << bits);
  endfunction

  initial begin
    int unsigned w, h, r;
    logic [15:0] g;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    pixels_sent = 0;
    quiet = 0;
    hold_req = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every mode on extreme pixels, gain extremes, undefined modes.
    run_phase(MODE_COPY, GainReset, 2, 1, 1, 1);
    run_phase(MODE_INVERT, GainReset, 2, 1, 1, 1);
    run_phase(MODE_GRAY, GainReset, 2, 1, 1, 1);
    run_phase(MODE_SEPIA, GainReset, 2, 1, 1, 1);
    run_phase(MODE_BRIGHT, 16'h0000, 2, 1, 1, 1);
    run_phase(MODE_BRIGHT, 16'hFFFF, 2, 1, 1, 1);
    run_phase(16'hFFFE, GainReset, 1, 1, 1, 1);
    run_phase(16'h0007, GainReset, 1, 1, 1, 1);
    // Blur: small frame, zero geometry acting as one, then drain checks.
    run_phase(MODE_BLUR, GainReset, 3, 3, 1, 1);
    run_phase(MODE_BLUR, GainReset, 0, 0, 2, 1);
    send_drain();

    // Receiver holds off while the sender keeps offering.
    wait_idle();
    write_reg(CFG_WIDTH, 16);
    write_reg(CFG_HEIGHT, 8);
    cfg_valid <= 1'b0;
    quiet = 1;
    hold_req = 1;
    send_frame(0, 1);
    quiet = 0;

    // Random phases until enough pixels have gone in.
    while (pixels_sent < 400) begin
      r = $urandom_range(0, 9);
      w = (r < 7) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      h = (w > 6) ? $urandom_range(0, 2) : $urandom_range(0, 5);
      r = $urandom_range(0, 9);
      g = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
      r = $urandom_range(0, 9);
      run_phase(hi_noise((r < 4) ? MODE_BLUR : $urandom_range(0, 7), 3), g,
                hi_noise(w, 11), hi_noise(h, 13), (w > 6) ? 1 : $urandom_range(1, 3),
                r == 9);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_px.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
